### rtl/vfs_pkg.sv
// ----------------------------------------------------------------------------
// VGA framebuffer scan-out package
// Shared widths, sizes, register indexes and reset values of the scan-out
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vfs_pkg;

  // Framebuffer geometry.
  localparam int ROW_BYTES = 52;
  localparam int ROWS      = 200;
  localparam int MEM_DEPTH = ROW_BYTES * ROWS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Shift position counts 1 .. ROW_BYTES*8, zero means idle.
  localparam int SHIFT_LAST = ROW_BYTES * 8;
  localparam int SP_W       = $clog2(SHIFT_LAST + 1);

  // Field widths of the request and the result.
  localparam int COL_W  = 6;
  localparam int ROW_W  = 8;
  localparam int PIX_W  = 8;
  localparam int H_W    = 16;
  localparam int V_W    = 10;
  localparam int REP_W  = 4;
  localparam int TICK_W = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H_TOTAL      = 3'd0,
    REG_HSYNC_WIDTH  = 3'd1,
    REG_H_START      = 3'd2,
    REG_V_TOTAL      = 3'd3,
    REG_VSYNC_WIDTH  = 3'd4,
    REG_V_START      = 3'd5,
    REG_REPEAT_COUNT = 3'd6,
    REG_BIT_TICKS    = 3'd7
  } cfg_reg_t;

  // Request modes.
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Register reset values.
  localparam logic [H_W-1:0]    RST_H_TOTAL      = 16'd2048;
  localparam logic [H_W-1:0]    RST_HSYNC_WIDTH  = 16'd144;
  localparam logic [H_W-1:0]    RST_H_START      = 16'd352;
  localparam logic [V_W-1:0]    RST_V_TOTAL      = 10'd625;
  localparam logic [V_W-1:0]    RST_VSYNC_WIDTH  = 10'd2;
  localparam logic [V_W-1:0]    RST_V_START      = 10'd24;
  localparam logic [REP_W-1:0]  RST_REPEAT_COUNT = 4'd3;
  localparam logic [TICK_W-1:0] RST_BIT_TICKS    = 8'd4;

  // Byte address of a framebuffer entry.
  function automatic logic [ADDR_W-1:0] fb_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    fb_addr = ADDR_W'(r) * ADDR_W'(ROW_BYTES) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

### rtl/vfs_if.sv
// ----------------------------------------------------------------------------
// VGA framebuffer scan-out channels
// Request channel (tick or framebuffer write) and result channel (sync
// levels and video bit), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [vfs_pkg::COL_W-1:0]    col_byte;
  logic [vfs_pkg::ROW_W-1:0]    row;
  logic [vfs_pkg::PIX_W-1:0]    pixels;

  modport source (output valid, output mode, output col_byte, output row,
                  output pixels, input ready);
  modport sink   (input valid, input mode, input col_byte, input row,
                  input pixels, output ready);
endinterface

interface vfs_out_if;
  logic valid;
  logic ready;
  logic hsync;
  logic vsync;
  logic pixel;
  logic shifting;

  modport source (output valid, output hsync, output vsync, output pixel,
                  output shifting, input ready);
  modport sink   (input valid, input hsync, input vsync, input pixel,
                  input shifting, output ready);
endinterface

`default_nettype wire

### rtl/vga_framebuffer_scanout_top.sv
// ----------------------------------------------------------------------------
// VGA framebuffer scan-out engine
// One-bit video timing and row shifter over a cleared-at-reset framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per timer tick (mode tick) or a framebuffer
//   byte write (mode write). Every request yields exactly one result on
//   out_ch: the hsync, vsync, pixel and shifting levels at that request.
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_data while the block is idle.
// Flow:
//   A request is taken every cycle while out_ch is not stalled and the
//   clear sweep is done. Accepting a request loads the frame store read and
//   the read stage; the read stage then moves into the output register.
// Reset:
//   rst clears timing state and loads the register defaults, then a sweep
//   writes zero to all 10400 framebuffer bytes, one per cycle; in_ch.ready
//   stays low until the sweep is done.
// Stall:
//   When out_ch.ready is low, the output register and the read stage hold
//   and in_ch.ready drops once both are full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module vga_framebuffer_scanout_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  vfs_in_if.sink                                in_ch,
  vfs_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [vfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vfs_pkg::*;

  // Configuration registers.
  logic [H_W-1:0]    h_total, hsync_width, h_start;
  logic [V_W-1:0]    v_total, vsync_width, v_start;
  logic [REP_W-1:0]  repeat_count;
  logic [TICK_W-1:0] bit_ticks;

  // Timing state.
  logic [H_W-1:0]    hcount, hcount_next;
  logic [V_W-1:0]    vcount, vcount_next;
  logic              display_on, display_on_next;
  logic [ROW_W-1:0]  row_pointer, row_pointer_next;
  logic [REP_W-1:0]  repeat_pass, repeat_pass_next;
  logic [SP_W-1:0]   shift_pos, shift_pos_next;
  logic [TICK_W-1:0] hold_ticks, hold_ticks_next;

  // Read stage and output register.
  logic              s1_valid, s1_hsync, s1_vsync, s1_shift, s1_bypass;
  logic [2:0]        s1_bit;
  logic [PIX_W-1:0]  s1_wbyte;
  logic              o_valid, o_hsync, o_vsync, o_pixel, o_shift;

  // Handshake and datapath signals.
  logic              clearing, accept, s1_adv, is_tick;
  logic              disp_now, start, cur_shift, wr_ok;
  logic [SP_W-1:0]   cur_sp, idx, sp_inc;
  logic [TICK_W-1:0] cur_hold;
  logic [TICK_W:0]   hold_inc, hold_lim;
  logic [REP_W:0]    pass_inc, rep_lim;
  logic [COL_W-1:0]  rd_col;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [PIX_W-1:0]  rd_data, pix_byte;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      h_total      <= RST_H_TOTAL;
      hsync_width  <= RST_HSYNC_WIDTH;
      h_start      <= RST_H_START;
      v_total      <= RST_V_TOTAL;
      vsync_width  <= RST_VSYNC_WIDTH;
      v_start      <= RST_V_START;
      repeat_count <= RST_REPEAT_COUNT;
      bit_ticks    <= RST_BIT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_H_TOTAL:      h_total      <= cfg_data[H_W-1:0];
        REG_HSYNC_WIDTH:  hsync_width  <= cfg_data[H_W-1:0];
        REG_H_START:      h_start      <= cfg_data[H_W-1:0];
        REG_V_TOTAL:      v_total      <= cfg_data[V_W-1:0];
        REG_VSYNC_WIDTH:  vsync_width  <= cfg_data[V_W-1:0];
        REG_V_START:      v_start      <= cfg_data[V_W-1:0];
        REG_REPEAT_COUNT: repeat_count <= cfg_data[REP_W-1:0];
        REG_BIT_TICKS:    bit_ticks    <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the read stage moves on when the output register is free.
  assign s1_adv      = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !clearing && (!s1_valid || s1_adv);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.mode == MODE_TICK);

  // Display turn-on and row start happen only on a tick.
  always_comb begin
    disp_now  = display_on || (hcount == '0 && vcount == v_start);
    start     = is_tick && disp_now && shift_pos == '0 && hcount == h_start;
    cur_sp    = start ? SP_W'(1) : shift_pos;
    cur_hold  = start ? '0 : hold_ticks;
    cur_shift = (cur_sp != '0);
    idx       = cur_sp - 1'b1;
    rd_col    = cur_shift ? idx[SP_W-1:3] : '0;
    rd_addr   = fb_addr(row_pointer, rd_col);
    wr_ok     = !is_tick && (in_ch.col_byte < COL_W'(ROW_BYTES))
                && (in_ch.row < ROW_W'(ROWS));
    wr_addr   = fb_addr(in_ch.row, in_ch.col_byte);
  end

  // Shifter and counter advance for one tick.
  always_comb begin
    hold_lim         = (bit_ticks == '0) ? (TICK_W+1)'(1) : {1'b0, bit_ticks};
    rep_lim          = (repeat_count == '0) ? (REP_W+1)'(1) : {1'b0, repeat_count};
    hold_inc         = {1'b0, cur_hold} + 1'b1;
    sp_inc           = cur_sp + 1'b1;
    pass_inc         = {1'b0, repeat_pass} + 1'b1;
    display_on_next  = disp_now;
    row_pointer_next = row_pointer;
    repeat_pass_next = repeat_pass;
    shift_pos_next   = cur_sp;
    hold_ticks_next  = cur_hold;
    if (cur_shift) begin
      if (hold_inc < hold_lim) begin
        hold_ticks_next = hold_inc[TICK_W-1:0];
      end else begin
        hold_ticks_next = '0;
        shift_pos_next  = sp_inc;
        if (sp_inc > SP_W'(SHIFT_LAST)) begin
          shift_pos_next = '0;
          if (pass_inc >= rep_lim) begin
            repeat_pass_next = '0;
            if (row_pointer + 1'b1 >= ROW_W'(ROWS)) begin
              row_pointer_next = '0;
              display_on_next  = 1'b0;
            end else begin
              row_pointer_next = row_pointer + 1'b1;
            end
          end else begin
            repeat_pass_next = pass_inc[REP_W-1:0];
          end
        end
      end
    end
    if (hcount >= h_total) begin
      hcount_next = '0;
      vcount_next = (vcount >= v_total) ? '0 : vcount + 1'b1;
    end else begin
      hcount_next = hcount + 1'b1;
      vcount_next = vcount;
    end
  end

  // Timing state advances only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      hcount      <= '0;
      vcount      <= '0;
      display_on  <= 1'b0;
      row_pointer <= '0;
      repeat_pass <= '0;
      shift_pos   <= '0;
      hold_ticks  <= '0;
    end else if (accept && is_tick) begin
      hcount      <= hcount_next;
      vcount      <= vcount_next;
      display_on  <= display_on_next;
      row_pointer <= row_pointer_next;
      repeat_pass <= repeat_pass_next;
      shift_pos   <= shift_pos_next;
      hold_ticks  <= hold_ticks_next;
    end
  end

  // Frame store with its clear sweep.
  vfs_frame_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && wr_ok),
    .wr_addr  (wr_addr),
    .wr_data  (in_ch.pixels),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Read stage: levels of this request, waiting for the store byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hsync  <= (hcount < hsync_width);
      s1_vsync  <= (vcount < vsync_width);
      s1_shift  <= cur_shift;
      s1_bit    <= idx[2:0];
      s1_bypass <= wr_ok && cur_shift && (wr_addr == rd_addr);
      s1_wbyte  <= in_ch.pixels;
    end
  end

  // A write to the byte being shown takes effect in its own result.
  assign pix_byte = s1_bypass ? s1_wbyte : rd_data;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_hsync <= s1_hsync;
      o_vsync <= s1_vsync;
      o_shift <= s1_shift;
      o_pixel <= s1_shift && pix_byte[3'd7 - s1_bit];
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.hsync    = o_hsync;
  assign out_ch.vsync    = o_vsync;
  assign out_ch.pixel    = o_pixel;
  assign out_ch.shifting = o_shift;

endmodule

`default_nettype wire

### rtl/vfs_frame_mem.sv
// ----------------------------------------------------------------------------
// VGA framebuffer scan-out frame store
// One write port and one registered read port over the framebuffer bytes.
// After reset a sweep writes zero to every entry, one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_frame_mem (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [vfs_pkg::ADDR_W-1:0]   wr_addr,
  input  wire logic [vfs_pkg::PIX_W-1:0]    wr_data,
  input  wire logic                         rd_en,
  input  wire logic [vfs_pkg::ADDR_W-1:0]   rd_addr,
  output logic      [vfs_pkg::PIX_W-1:0]    rd_data,
  output logic                              clearing
);
  import vfs_pkg::*;

  logic [PIX_W-1:0]  mem [MEM_DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;
  logic              mem_we;

  // Clear sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // The sweep owns the write port until it finishes.
  always_comb begin
    mem_we    = clearing | wr_en;
    mem_waddr = clearing ? clr_addr : wr_addr;
    mem_wdata = clearing ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read; returns the old byte when written in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
